### rtl/i2j_pkg.sv
//------------------------------------------------------------------------------
// i2j_pkg
// Shared types, character codes and the per-byte decode function of the
// ISO-2022-JP to wide character decoder.
//------------------------------------------------------------------------------
`default_nettype none

package i2j_pkg;

	localparam int I2J_QUEUE_DEPTH = 2;
	localparam int MAX_RES         = 3;

	localparam logic [7:0] ESC_BYTE  = 8'h1B;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PAREN  = 8'h28;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_B      = 8'h42;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_J      = 8'h4A;

	localparam logic [15:0] KANJI_MARK = 16'h8080;
	localparam logic [7:0]  KANA_MARK  = 8'h80;
	localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

	typedef enum logic [1:0] {
		MODE_ASCII = 2'd0,
		MODE_KANJI = 2'd1,
		MODE_KANA  = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_SEEN = 2'd1,
		ESC_HELD = 2'd2
	} esc_stage_t;

	typedef struct packed {
		mode_t      mode;
		esc_stage_t stage;
		logic [7:0] held;
		logic       lead_pend;
		logic [7:0] lead;
		logic [15:0] count;
	} dec_state_t;

	localparam dec_state_t RESET_STATE = '{
		mode:      MODE_ASCII,
		stage:     ESC_NONE,
		held:      8'h00,
		lead_pend: 1'b0,
		lead:      8'h00,
		count:     16'h0000
	};

	// One result: a character, or a terminator whose value is the count.
	typedef struct packed {
		logic        is_end;
		logic [15:0] value;
	} res_t;

	typedef struct packed {
		logic [1:0]               num;
		res_t [MAX_RES-1:0]       res;
	} bundle_t;

	typedef struct packed {
		dec_state_t st;
		bundle_t    bnd;
	} step_t;

	function automatic step_t i2j_put_char(step_t t, logic [15:0] wc);
		step_t o;
		o = t;
		o.bnd.res[o.bnd.num] = '{is_end: 1'b0, value: wc};
		o.bnd.num = o.bnd.num + 2'd1;
		if (o.st.count != COUNT_MAX) begin
			o.st.count = o.st.count + 16'd1;
		end
		return o;
	endfunction

	function automatic step_t i2j_put_end(step_t t);
		step_t o;
		o = t;
		o.bnd.res[o.bnd.num] = '{is_end: 1'b1, value: t.st.count};
		o.bnd.num = o.bnd.num + 2'd1;
		o.st = RESET_STATE;
		return o;
	endfunction

	// Handles one byte while no escape sequence is pending.
	function automatic step_t i2j_feed(step_t t, logic [7:0] b);
		step_t o;
		o = t;
		if (t.st.lead_pend) begin
			if (b == 8'h00) begin
				o = i2j_put_end(t);
			end else begin
				o = i2j_put_char(t, {t.st.lead, b} | KANJI_MARK);
				o.st.lead_pend = 1'b0;
				o.st.lead = 8'h00;
			end
		end else if (b == 8'h00) begin
			o = i2j_put_end(t);
		end else if (b == ESC_BYTE) begin
			o.st.stage = ESC_SEEN;
		end else if (t.st.mode == MODE_KANJI) begin
			o.st.lead_pend = 1'b1;
			o.st.lead = b;
		end else begin
			o = i2j_put_char(t, {8'h00, (t.st.mode == MODE_KANA) ? (b | KANA_MARK) : b});
		end
		return o;
	endfunction

	function automatic step_t i2j_step(dec_state_t s, logic [7:0] b);
		step_t      t;
		logic [7:0] h;
		logic       matched;
		t.st  = s;
		t.bnd = '0;
		h = s.held;
		matched = 1'b1;
		unique case (s.stage)
			ESC_SEEN: begin
				if (b == CH_DOLLAR || b == CH_PAREN) begin
					t.st.held  = b;
					t.st.stage = ESC_HELD;
				end else begin
					t.st.stage = ESC_NONE;
					t = i2j_put_char(t, {8'h00, ESC_BYTE});
					t = i2j_feed(t, b);
				end
			end
			ESC_HELD: begin
				if (h == CH_DOLLAR && (b == CH_B || b == CH_AT)) begin
					t.st.mode = MODE_KANJI;
				end else if (h == CH_PAREN && (b == CH_J || b == CH_B)) begin
					t.st.mode = MODE_ASCII;
				end else if (h == CH_PAREN && b == CH_I) begin
					t.st.mode = MODE_KANA;
				end else begin
					matched = 1'b0;
				end
				t.st.stage = ESC_NONE;
				t.st.held  = 8'h00;
				if (!matched) begin
					t = i2j_put_char(t, {8'h00, ESC_BYTE});
					t = i2j_feed(t, h);
					t = i2j_feed(t, b);
				end
			end
			default: begin
				t.st.stage = ESC_NONE;
				t = i2j_feed(t, b);
			end
		endcase
		return t;
	endfunction

endpackage

`default_nettype wire

### rtl/iso2022jp_to_wide_decoder.sv
//------------------------------------------------------------------------------
// iso2022jp_to_wide_decoder
// Decodes an ISO-2022-JP byte stream into 16-bit wide characters.
//
// Input channel: data_valid, data_stall, data_byte. One byte is transferred
// at each edge with data_valid high and data_stall low; a zero byte ends the
// string. Output channel: result_valid, result_stall and the result fields.
// Each result is a character (char_valid) or the terminator of a string
// (end_of_string, with char_count).
// A byte gives zero to three results, which pass through the bundle queue
// into the output register. One byte is taken each cycle while the queue is
// not full, and one result leaves each cycle while the receiver does not
// stall; a byte that gives two or three results stays at the head of the
// bundle queue between the decoder and the output (QUEUE_DEPTH bundles) until
// its last result is loaded. When the receiver stalls, the output register
// holds, the queue fills and data_stall rises once the queue is full.
// Reset puts the decoder in ASCII mode with no escape or lead byte pending,
// a count of zero, an empty queue and no result valid.
//------------------------------------------------------------------------------
`default_nettype none

module iso2022jp_to_wide_decoder #(
	parameter int QUEUE_DEPTH = i2j_pkg::I2J_QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        data_valid,
	output logic             data_stall,
	input  wire logic [7:0]  data_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [15:0]      wide_char,
	output logic             char_valid,
	output logic             end_of_string,
	output logic [15:0]      char_count
);
	import i2j_pkg::*;

	logic    push;
	bundle_t push_bnd;
	logic    queue_full;
	logic    head_valid;
	bundle_t head;
	logic    pop;

	i2j_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.queue_full (queue_full),
		.push       (push),
		.push_bnd   (push_bnd)
	);

	i2j_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_bnd   (push_bnd),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	i2j_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.wide_char     (wide_char),
		.char_valid    (char_valid),
		.end_of_string (end_of_string),
		.char_count    (char_count)
	);

endmodule

`default_nettype wire

### rtl/i2j_front.sv
//------------------------------------------------------------------------------
// i2j_front
// Accepts input bytes, tracks the shift mode and escape state, and turns each
// byte into a bundle of zero to three results for the queue.
//------------------------------------------------------------------------------
`default_nettype none

module i2j_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             data_valid,
	output logic                  data_stall,
	input  wire logic [7:0]       data_byte,
	input  wire logic             queue_full,
	output logic                  push,
	output i2j_pkg::bundle_t      push_bnd
);
	import i2j_pkg::*;

	dec_state_t st_q;
	step_t      nxt;
	logic       accept;

	assign nxt        = i2j_step(st_q, data_byte);
	assign data_stall = queue_full;
	assign accept     = data_valid && !queue_full;
	assign push       = accept && (nxt.bnd.num != 2'd0);
	assign push_bnd   = nxt.bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= RESET_STATE;
		end else if (accept) begin
			st_q <= nxt.st;
		end
	end

endmodule

`default_nettype wire

### rtl/i2j_queue.sv
//------------------------------------------------------------------------------
// i2j_queue
// Short queue of result bundles between the front and the back.
//------------------------------------------------------------------------------
`default_nettype none

module i2j_queue #(
	parameter int DEPTH = i2j_pkg::I2J_QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire i2j_pkg::bundle_t push_bnd,
	output logic                  full,
	output logic                  head_valid,
	output i2j_pkg::bundle_t      head,
	input  wire logic             pop
);
	import i2j_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_bnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from an empty queue");
	a_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_bnd.num != 2'd0))
		else $error("empty bundle pushed");

endmodule

`default_nettype wire

### rtl/i2j_back.sv
//------------------------------------------------------------------------------
// i2j_back
// Walks the head bundle one result at a time into the output register.
//------------------------------------------------------------------------------
`default_nettype none

module i2j_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head_valid,
	input  wire i2j_pkg::bundle_t head,
	output logic                  pop,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic [15:0]           wide_char,
	output logic                  char_valid,
	output logic                  end_of_string,
	output logic [15:0]           char_count
);
	import i2j_pkg::*;

	logic [1:0]  idx_q;
	logic        out_valid_q;
	logic [15:0] wide_char_q;
	logic        char_valid_q;
	logic        end_q;
	logic [15:0] count_q;
	logic        load;
	logic        last;
	res_t        cur;

	assign cur  = head.res[idx_q];
	assign load = head_valid && (!out_valid_q || !result_stall);
	assign last = (2'(idx_q + 2'd1) == head.num);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= last ? 2'd0 : 2'(idx_q + 2'd1);
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			wide_char_q  <= cur.is_end ? 16'h0000 : cur.value;
			char_valid_q <= !cur.is_end;
			end_q        <= cur.is_end;
			count_q      <= cur.is_end ? cur.value : 16'h0000;
		end
	end

	assign result_valid  = out_valid_q;
	assign wide_char     = wide_char_q;
	assign char_valid    = char_valid_q;
	assign end_of_string = end_q;
	assign char_count    = count_q;

	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (idx_q < head.num))
		else $error("result index beyond bundle");
	a_pop_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> load)
		else $error("bundle released without a transfer");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> (idx_q == 2'd0))
		else $error("result index not cleared while queue empty");

endmodule

`default_nettype wire
